// ===== src/stf_pkg.sv =====
package stf_pkg;

   localparam int MODES = 64;
   localparam int MODE_W = (MODES > 1) ? $clog2(MODES) : 1;
   localparam int CORDIC_STEPS = 24;
   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
   localparam int DB_W = 48;
   localparam logic signed [39:0] FRAC_POINT_TWO = 40'sd13107;
   localparam logic signed [39:0] FRAC_ROUND = 40'sd32768;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [3:0] SEL_KX = 4'd0;
   localparam logic [3:0] SEL_KY = 4'd1;
   localparam logic [3:0] SEL_KZ = 4'd2;
   localparam logic [3:0] SEL_OFF = 4'd3;
   localparam logic [3:0] SEL_CAX = 4'd4;
   localparam logic [3:0] SEL_CAY = 4'd5;
   localparam logic [3:0] SEL_CAZ = 4'd6;
   localparam logic [3:0] SEL_SAX = 4'd7;
   localparam logic [3:0] SEL_SAY = 4'd8;

   localparam logic [2:0] CSR_B0_X = 3'd0;
   localparam logic [2:0] CSR_B0_Y = 3'd1;
   localparam logic [2:0] CSR_B0_Z = 3'd2;
   localparam logic [2:0] CSR_U0_X = 3'd3;
   localparam logic [2:0] CSR_U0_Y = 3'd4;
   localparam logic [2:0] CSR_U0_Z = 3'd5;
   localparam logic [2:0] CSR_SHOCK_X = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_KMUL,
      S_ROT,
      S_AMUL,
      S_FIN
   } state_type;

   typedef struct packed {
      logic              en;
      logic [MODE_W-1:0] addr;
      logic [3:0]        sel;
      logic [31:0]       value;
   } mem_wr_type;

   typedef struct packed {
      logic [31:0] kx;
      logic [31:0] ky;
      logic [31:0] kz;
      logic [31:0] off;
      logic [23:0] cax;
      logic [23:0] cay;
      logic [23:0] caz;
      logic [23:0] sax;
      logic [23:0] say;
   } mode_coef_type;

   typedef struct packed {
      logic        load;
      logic        step;
      logic [4:0]  idx;
      logic [31:0] phase;
   } cordic_ctl_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/shock_turbulence_field_eval.sv =====
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  cmd, mode_index, coef_select, coef_value, pos_x/y/z
// rsp      out        rsp_valid/rsp_stall  field_x/y/z, flow_x/y/z, downstream
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// a coefficient write is taken in the idle state; a query runs, per mode, one memory
// read, the k.x products on the shared 32x32 multiplier, 24 cordic rotations and the
// amplitude terms on the same multiplier.
// req_stall is high while a query runs; the finished beat waits in the rsp register
// and a following query holds in its last cycle until that beat is taken.
// synchronous reset clears the sequencer, rsp_valid and the csr registers.
module shock_turbulence_field_eval (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [5:0]         req_mode_index,
   input  logic [3:0]         req_coef_select,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_field_x,
   output logic signed [31:0] rsp_field_y,
   output logic signed [31:0] rsp_field_z,
   output logic signed [23:0] rsp_flow_x,
   output logic signed [24:0] rsp_flow_y,
   output logic signed [24:0] rsp_flow_z,
   output logic               rsp_downstream,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import stf_pkg::*;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic down_ff, down_in;
   logic [47:0] acc_ff, acc_in, acc_sum;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [DB_W-1:0] dbx_ff, dbx_in, dby_ff, dby_in, dbz_ff, dbz_in, term;
   logic signed [31:0] mul_a, mul_b;

   logic signed [23:0] b0x_ff, b0y_ff, b0z_ff, u0x_ff, u0y_ff, u0z_ff;
   logic signed [31:0] shock_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] fx_ff, fx_in, fy_ff, fy_in, fz_ff, fz_in;
   logic signed [23:0] ux_ff, ux_in;
   logic signed [24:0] uy_ff, uy_in, uz_ff, uz_in;
   logic dn_ff, dn_in;

   mem_wr_type     wr;
   mode_coef_type  coef;
   cordic_ctl_type cctl;
   logic signed [31:0] cos_v, sin_v;

   logic signed [DB_W-1:0] bx, by, bz_s, bz;
   logic signed [39:0] frac40;
   logic signed [24:0] frac;

   function automatic logic signed [31:0] sat32(input logic signed [DB_W-1:0] v);
      logic signed [31:0] r;
      if (v > DB_W'(64'sd2147483647)) r = 32'sh7FFF_FFFF;
      else if (v < -DB_W'(64'sd2147483648)) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   stf_mode_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (mode_ff),
      .rd_data (coef)
   );

   stf_cordic u_cordic (
      .clock   (clock),
      .ctl     (cctl),
      .cos_out (cos_v),
      .sin_out (sin_v)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0x_ff <= '0;
         b0y_ff <= '0;
         b0z_ff <= '0;
         u0x_ff <= '0;
         u0y_ff <= '0;
         u0z_ff <= '0;
         shock_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_B0_X:    b0x_ff <= csr_data[23:0];
            CSR_B0_Y:    b0y_ff <= csr_data[23:0];
            CSR_B0_Z:    b0z_ff <= csr_data[23:0];
            CSR_U0_X:    u0x_ff <= csr_data[23:0];
            CSR_U0_Y:    u0y_ff <= csr_data[23:0];
            CSR_U0_Z:    u0z_ff <= csr_data[23:0];
            CSR_SHOCK_X: shock_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign prod_in = mul_a * mul_b;
   assign acc_sum = acc_ff + prod_ff[47:0];
   assign term = DB_W'(signed'(prod_ff[63:30]));

   always_comb begin
      bx = DB_W'(b0x_ff) + dbx_ff;
      by = DB_W'(b0y_ff) + dby_ff;
      bz_s = DB_W'(b0z_ff) + dbz_ff;
      bz = down_ff ? (bz_s + (bz_s >>> 1)) : bz_s;
      frac40 = (40'(u0x_ff) * FRAC_POINT_TWO + FRAC_ROUND) >>> 16;
      frac = frac40[24:0];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      mode_in = mode_ff;
      px_in = px_ff;
      py_in = py_ff;
      pz_in = pz_ff;
      down_in = down_ff;
      acc_in = acc_ff;
      dbx_in = dbx_ff;
      dby_in = dby_ff;
      dbz_in = dbz_ff;
      mul_a = '0;
      mul_b = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      fx_in = fx_ff;
      fy_in = fy_ff;
      fz_in = fz_ff;
      ux_in = ux_ff;
      uy_in = uy_ff;
      uz_in = uz_ff;
      dn_in = dn_ff;
      wr.en = 1'b0;
      wr.addr = MODE_W'(req_mode_index);
      wr.sel = req_coef_select;
      wr.value = req_coef_value;
      cctl.load = 1'b0;
      cctl.step = 1'b0;
      cctl.idx = cnt_ff;
      cctl.phase = acc_sum[47:16] + coef.off;
      req_stall = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_WRITE) begin
                  wr.en = (32'(req_mode_index) < MODES);
               end else begin
                  px_in = req_pos_x;
                  py_in = req_pos_y;
                  pz_in = req_pos_z;
                  down_in = (req_pos_x >= shock_ff);
                  dbx_in = '0;
                  dby_in = '0;
                  dbz_in = '0;
                  mode_in = '0;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cnt_in = '0;
            state_in = S_KMUL;
         end
         S_KMUL: begin
            case (cnt_ff)
               5'd0: begin mul_a = coef.kx; mul_b = px_ff; end
               5'd1: begin mul_a = coef.ky; mul_b = py_ff; end
               5'd2: begin mul_a = coef.kz; mul_b = pz_ff; end
               default: ;
            endcase
            if (cnt_ff == 5'd1) acc_in = prod_ff[47:0];
            else if (cnt_ff != 5'd0) acc_in = acc_sum;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               cctl.load = 1'b1;
               cnt_in = '0;
               state_in = S_ROT;
            end
         end
         S_ROT: begin
            cctl.step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CORDIC_STEPS - 1)) begin
               cnt_in = '0;
               state_in = S_AMUL;
            end
         end
         S_AMUL: begin
            case (cnt_ff)
               5'd0: begin mul_a = 32'(signed'(coef.cax)); mul_b = cos_v; end
               5'd1: begin mul_a = 32'(signed'(coef.sax)); mul_b = sin_v; end
               5'd2: begin mul_a = 32'(signed'(coef.cay)); mul_b = cos_v; end
               5'd3: begin mul_a = 32'(signed'(coef.say)); mul_b = sin_v; end
               5'd4: begin mul_a = 32'(signed'(coef.caz)); mul_b = cos_v; end
               default: ;
            endcase
            // product of the previous cycle lands in its component
            case (cnt_ff)
               5'd1, 5'd2: dbx_in = dbx_ff + term;
               5'd3, 5'd4: dby_in = dby_ff + term;
               5'd5:       dbz_in = dbz_ff + term;
               default: ;
            endcase
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd5) begin
               cnt_in = '0;
               if (mode_ff == MODE_W'(MODES - 1)) begin
                  state_in = S_FIN;
               end else begin
                  mode_in = mode_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_FIN: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               fx_in = sat32(bx);
               fy_in = sat32(by);
               fz_in = sat32(bz);
               dn_in = down_ff;
               if (down_ff) begin
                  ux_in = u0x_ff >>> 2;
                  uy_in = 25'(u0y_ff) + frac;
                  uz_in = 25'(u0z_ff) + frac;
               end else begin
                  ux_in = u0x_ff;
                  uy_in = 25'(u0y_ff);
                  uz_in = 25'(u0z_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         mode_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      pz_ff <= pz_in;
      down_ff <= down_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      dbx_ff <= dbx_in;
      dby_ff <= dby_in;
      dbz_ff <= dbz_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      fz_ff <= fz_in;
      ux_ff <= ux_in;
      uy_ff <= uy_in;
      uz_ff <= uz_in;
      dn_ff <= dn_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_field_x = fx_ff;
   assign rsp_field_y = fy_ff;
   assign rsp_field_z = fz_ff;
   assign rsp_flow_x = ux_ff;
   assign rsp_flow_y = uy_ff;
   assign rsp_flow_z = uz_ff;
   assign rsp_downstream = dn_ff;

endmodule

// ===== src/stf_mode_mem.sv =====
module stf_mode_mem (
   input  logic                  clock,
   input  stf_pkg::mem_wr_type   wr,
   input  logic [stf_pkg::MODE_W-1:0] rd_addr,
   output stf_pkg::mode_coef_type rd_data
);
   import stf_pkg::*;

   logic [31:0] kx_mem [MODES];
   logic [31:0] ky_mem [MODES];
   logic [31:0] kz_mem [MODES];
   logic [31:0] off_mem [MODES];
   logic [23:0] cax_mem [MODES];
   logic [23:0] cay_mem [MODES];
   logic [23:0] caz_mem [MODES];
   logic [23:0] sax_mem [MODES];
   logic [23:0] say_mem [MODES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         case (wr.sel)
            SEL_KX:  kx_mem[wr.addr] <= wr.value;
            SEL_KY:  ky_mem[wr.addr] <= wr.value;
            SEL_KZ:  kz_mem[wr.addr] <= wr.value;
            SEL_OFF: off_mem[wr.addr] <= wr.value;
            SEL_CAX: cax_mem[wr.addr] <= wr.value[23:0];
            SEL_CAY: cay_mem[wr.addr] <= wr.value[23:0];
            SEL_CAZ: caz_mem[wr.addr] <= wr.value[23:0];
            SEL_SAX: sax_mem[wr.addr] <= wr.value[23:0];
            SEL_SAY: say_mem[wr.addr] <= wr.value[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rd_data.kx  <= kx_mem[rd_addr];
      rd_data.ky  <= ky_mem[rd_addr];
      rd_data.kz  <= kz_mem[rd_addr];
      rd_data.off <= off_mem[rd_addr];
      rd_data.cax <= cax_mem[rd_addr];
      rd_data.cay <= cay_mem[rd_addr];
      rd_data.caz <= caz_mem[rd_addr];
      rd_data.sax <= sax_mem[rd_addr];
      rd_data.say <= say_mem[rd_addr];
   end

endmodule

// ===== src/stf_cordic.sv =====
module stf_cordic (
   input  logic                   clock,
   input  stf_pkg::cordic_ctl_type ctl,
   output logic signed [31:0]     cos_out,
   output logic signed [31:0]     sin_out
);
   import stf_pkg::*;

   logic signed [32:0] x_ff, x_in;
   logic signed [32:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic               neg_ff, neg_in;
   logic               fold;
   logic [31:0]        p;
   logic signed [32:0] dx, dy;
   logic signed [33:0] at;

   always_comb begin
      // fold into [-1/4, 1/4) turn, negate both outputs afterwards
      fold = (ctl.phase[31:30] == 2'd1) || (ctl.phase[31:30] == 2'd2);
      p = fold ? (ctl.phase + 32'h8000_0000) : ctl.phase;
      dx = y_ff >>> ctl.idx;
      dy = x_ff >>> ctl.idx;
      at = signed'({2'b00, atan_turn(ctl.idx)});
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      neg_in = neg_ff;
      if (ctl.load) begin
         x_in = CORDIC_X0;
         y_in = '0;
         z_in = 34'(signed'(p));
         neg_in = fold;
      end else if (ctl.step) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      neg_ff <= neg_in;
   end

   assign cos_out = neg_ff ? 32'(-x_ff) : 32'(x_ff);
   assign sin_out = neg_ff ? 32'(-y_ff) : 32'(y_ff);

endmodule
